FILE: hdl/msv_pkg.sv
// Package for the Mobius linear sieve: field widths, status codes and the
// sequencer state type. No dependencies.
package msv_pkg;

   localparam int NUM_W   = 17;   // integer and limit width
   localparam int MU_W    = 2;    // two's complement mu
   localparam int TOTAL_W = 14;   // reported prime total
   localparam int STAT_W  = 2;    // status code width
   localparam int REQ_W   = 24;   // request tdata width (whole bytes)
   localparam int RSP_W   = 24;   // response tdata width (whole bytes)
   localparam int CSR_W   = 24;   // csr tdata width (whole bytes)

   localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STAT_W-1:0] STATUS_ORDER = 2'd1;
   localparam logic [STAT_W-1:0] STATUS_LIMIT = 2'd2;

   localparam logic [MU_W-1:0] MU_ZERO = 2'b00;
   localparam logic [MU_W-1:0] MU_ONE  = 2'b01;
   localparam logic [MU_W-1:0] MU_NEG  = 2'b11;

   typedef enum logic [8:0] {
      ST_CLEAR = 9'b000000001,
      ST_IDLE  = 9'b000000010,
      ST_LOOK  = 9'b000000100,
      ST_FETCH = 9'b000001000,
      ST_MUL   = 9'b000010000,
      ST_CHECK = 9'b000100000,
      ST_DIV   = 9'b001000000,
      ST_MARK  = 9'b010000000,
      ST_DONE  = 9'b100000000
   } state_type;

endpackage

FILE: hdl/msv_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module msv_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/msv_mul.sv
// Multiply unit of the sieve: registers prime times integer and
// compares the product against the limit. Uses msv_pkg.
module msv_mul
   import msv_pkg::*;
#(
   parameter int LIM_W = 21
) (
   input  logic               clock,
   input  logic               enable,
   input  logic [NUM_W-1:0]   factor_a,
   input  logic [NUM_W-1:0]   factor_b,
   input  logic [LIM_W-1:0]   limit,
   output logic [2*NUM_W-1:0] product,
   output logic               over
);

   logic [2*NUM_W-1:0] prod_ff;
   logic [2*NUM_W-1:0] prod_in;

   // One 17x17 multiply per use, registered.
   assign prod_in = factor_a * factor_b;

   always_ff @(posedge clock) begin
      if (enable) begin
         prod_ff <= prod_in;
      end
   end

   // The limit never holds more significant bits than the product.
   assign product = prod_ff;
   assign over    = prod_ff > (2*NUM_W)'(limit);

endmodule

FILE: hdl/mobius_linear_sieve.sv
// Top level of the linear sieve producing the Mobius function.
// Uses msv_pkg, msv_ram and msv_mul.
//
// Integers are fed in order 1, 2, 3 ...; each beat returns mu, a prime flag,
// the running prime count and a status. After reset the block clears its
// mark store and takes no request meanwhile. An accepted integer then looks
// up its mark and walks the stored primes, one visit per multiple it marks:
// each such visit reads the prime list, multiplies in the multiplier, runs
// a shift-and-subtract remainder over the 17 integer bits to test whether
// the prime divides the integer, and writes the mark store. The walk ends
// as soon as a prime divides the integer, when a product passes the limit,
// or when the stored primes run out. A rejected integer goes straight to
// the output. The finished beat sits in an output register so the next
// request can be accepted while it waits.
module mobius_linear_sieve
   import msv_pkg::*;
#(
   parameter int MAX_N      = 65536,
   parameter int MAX_PRIMES = 8192
) (
   input  logic             clock,
   input  logic             reset,
   // bits 16:0 number
   input  logic [REQ_W-1:0] req_tdata,
   input  logic             req_tvalid,
   output logic             req_tready,
   // bits 1:0 mobius_value, 2 is_prime, 16:3 prime_total, 18:17 status
   output logic [RSP_W-1:0] rsp_tdata,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // bits 16:0 upper_limit
   input  logic [CSR_W-1:0] csr_tdata,
   input  logic             csr_tvalid,
   output logic             csr_tready
);

   localparam int AW   = $clog2(MAX_N + 1);
   localparam int LW   = AW + NUM_W;
   localparam int PW   = $clog2(MAX_PRIMES);
   localparam int CW   = $clog2(MAX_PRIMES + 1);
   localparam int MW   = 1 + MU_W;
   localparam int BW   = $clog2(NUM_W);

   state_type state_ff, state_in;
   logic [NUM_W-1:0] lim_ff, num_ff, exp_ff, exp_in, p_ff;
   logic [NUM_W-1:0] rem_ff, rem_in;
   logic [BW-1:0] bit_ff, bit_in;
   logic [CW-1:0] cnt_ff, cnt_in, j_ff, j_in;
   logic [MU_W-1:0] mu_ff, mu_in;
   logic prime_ff, prime_in;
   logic [STAT_W-1:0] stat_ff, stat_in;
   logic [AW-1:0] clr_ff;
   logic rsp_valid_ff;
   logic [RSP_W-1:0] rsp_data_ff;

   logic [NUM_W-1:0] req_num;
   logic [LW-1:0] lim_eff, req_ext;
   logic req_fire, rsp_free;
   logic mem_we, pl_we;
   logic [AW-1:0] mem_waddr, mem_raddr;
   logic [MW-1:0] mem_wdata, mem_rdata;
   logic [NUM_W-1:0] pl_rdata;
   logic rd_mark;
   logic [MU_W-1:0] rd_mu, mu_new;
   logic [2*NUM_W-1:0] prod;
   logic over, hit;
   logic [NUM_W:0] rem_sh, rem_sub;
   logic rem_ge;
   logic [CW+TOTAL_W-1:0] tot_ext;

   assign req_num    = req_tdata[NUM_W-1:0];
   assign req_ext    = LW'(req_num);
   assign lim_eff    = (LW'(lim_ff) > LW'(MAX_N)) ? LW'(MAX_N) : LW'(lim_ff);
   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign csr_tready = 1'b1;
   assign rd_mark    = mem_rdata[MU_W];
   assign rd_mu      = mem_rdata[MU_W-1:0];
   assign hit        = (rem_ff == '0);
   assign mu_new     = hit ? MU_ZERO : (MU_W'(0) - mu_ff);
   assign tot_ext    = (CW+TOTAL_W)'(cnt_ff);

   // Remainder step: shift in the next integer bit, subtract the prime if it fits.
   assign rem_sh  = {rem_ff, num_ff[bit_ff]};
   assign rem_ge  = (rem_sh >= {1'b0, p_ff});
   assign rem_sub = rem_sh - {1'b0, p_ff};

   // Mark store: composite flag and mu per integer.
   assign mem_raddr = req_ext[AW-1:0];
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = clr_ff;
      mem_wdata = '0;
      if (state_ff == ST_CLEAR) begin
         mem_we = 1'b1;
      end else if (state_ff == ST_MARK) begin
         mem_we    = 1'b1;
         mem_waddr = prod[AW-1:0];
         mem_wdata = {1'b1, mu_new};
      end
   end

   msv_ram #(.WIDTH(MW), .DEPTH(MAX_N + 1)) u_marks (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   // Prime list, appended in order.
   assign pl_we = (state_ff == ST_LOOK) && (num_ff != NUM_W'(1)) && !rd_mark
                  && (cnt_ff < CW'(MAX_PRIMES));

   msv_ram #(.WIDTH(NUM_W), .DEPTH(MAX_PRIMES)) u_primes (
      .clock   (clock),
      .wr_en   (pl_we),
      .wr_addr (cnt_ff[PW-1:0]),
      .wr_data (num_ff),
      .rd_addr (j_ff[PW-1:0]),
      .rd_data (pl_rdata)
   );

   msv_mul #(.LIM_W(LW)) u_mul (
      .clock    (clock),
      .enable   (state_ff == ST_MUL),
      .factor_a (pl_rdata),
      .factor_b (num_ff),
      .limit    (lim_eff),
      .product  (prod),
      .over     (over)
   );

   // Sequencer next state and working registers.
   always_comb begin
      state_in = state_ff;
      exp_in   = exp_ff;
      cnt_in   = cnt_ff;
      j_in     = j_ff;
      mu_in    = mu_ff;
      prime_in = prime_ff;
      stat_in  = stat_ff;
      rem_in   = rem_ff;
      bit_in   = bit_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == AW'(MAX_N)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               mu_in    = MU_ZERO;
               prime_in = 1'b0;
               if (req_num != exp_ff) begin
                  stat_in  = STATUS_ORDER;
                  state_in = ST_DONE;
               end else if (req_ext > lim_eff) begin
                  stat_in  = STATUS_LIMIT;
                  state_in = ST_DONE;
               end else begin
                  stat_in  = STATUS_OK;
                  state_in = ST_LOOK;
               end
            end
         end
         ST_LOOK: begin
            j_in   = '0;
            exp_in = num_ff + NUM_W'(1);
            if (num_ff == NUM_W'(1)) begin
               mu_in = MU_ONE;
            end else if (!rd_mark) begin
               mu_in    = MU_NEG;
               prime_in = 1'b1;
               if (cnt_ff < CW'(MAX_PRIMES)) begin
                  cnt_in = cnt_ff + CW'(1);
               end
            end else begin
               mu_in = rd_mu;
            end
            state_in = ST_FETCH;
         end
         ST_FETCH: begin
            state_in = (j_ff < cnt_ff) ? ST_MUL : ST_DONE;
         end
         ST_MUL: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (over) begin
               state_in = ST_DONE;
            end else begin
               rem_in   = '0;
               bit_in   = BW'(NUM_W - 1);
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            rem_in = rem_ge ? rem_sub[NUM_W-1:0] : rem_sh[NUM_W-1:0];
            if (bit_ff == '0) begin
               state_in = ST_MARK;
            end else begin
               bit_in = bit_ff - BW'(1);
            end
         end
         ST_MARK: begin
            if (hit) begin
               state_in = ST_DONE;
            end else begin
               j_in     = j_ff + CW'(1);
               state_in = ST_FETCH;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         exp_ff       <= NUM_W'(1);
         cnt_ff       <= '0;
         lim_ff       <= NUM_W'(65536);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         exp_ff   <= exp_in;
         cnt_ff   <= cnt_in;
         if (state_ff == ST_CLEAR) begin
            clr_ff <= clr_ff + AW'(1);
         end
         if (csr_tvalid && csr_tready) begin
            lim_ff <= csr_tdata[NUM_W-1:0];
         end
         if (state_ff == ST_DONE && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      j_ff     <= j_in;
      mu_ff    <= mu_in;
      prime_ff <= prime_in;
      stat_ff  <= stat_in;
      rem_ff   <= rem_in;
      bit_ff   <= bit_in;
      if (req_fire) begin
         num_ff <= req_num;
      end
      if (state_ff == ST_MUL) begin
         p_ff <= pl_rdata;
      end
      if (state_ff == ST_DONE && rsp_free) begin
         rsp_data_ff <= RSP_W'({stat_ff, tot_ext[TOTAL_W-1:0], prime_ff, mu_ff});
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // A prime with status ok always reports mu of minus one.
   a_prime_mu: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[18:17] == STATUS_OK && rsp_tdata[2]) |->
      (rsp_tdata[1:0] == MU_NEG))
      else $error("prime beat without mu of minus one");

   // The prime count never passes the list capacity.
   a_cnt_cap: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(MAX_PRIMES))
      else $error("prime count above capacity");

   // The block is not ready again in the cycle after it accepts a request.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_tready)
      else $error("request taken back to back");

   // Errors leave the expected integer unchanged.
   a_err_keep: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && stat_ff != STATUS_OK) |-> $stable(exp_ff))
      else $error("error beat changed sieve position");

endmodule

FILE: tb/tb.sv
// Self-checking testbench for mobius_linear_sieve: a mostly in-order integer
// stream is fed through, each result beat is compared with a built-in sieve predictor.
// Depends on msv_pkg and the mobius_linear_sieve RTL.
module tb
   import msv_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SIEVE_N      = 65536;
   localparam int SIEVE_PRIMES = 8192;
   localparam int CYCLE_LIMIT  = 4000000;

   typedef struct packed {
      logic [STAT_W-1:0]  status;
      logic [TOTAL_W-1:0] total;
      logic               prime;
      logic [MU_W-1:0]    mu;
   } sieve_result_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic [REQ_W-1:0] req_tdata = '0;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [RSP_W-1:0] rsp_tdata;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [CSR_W-1:0] csr_tdata = '0;
   logic             csr_tvalid = 1'b0;
   logic             csr_tready;

   // Predictor state, a private copy of the sieve.
   bit                 marks [0:SIEVE_N];
   logic [MU_W-1:0]    mu_store [0:SIEVE_N];
   int unsigned        prime_table [0:SIEVE_PRIMES-1];
   int unsigned        prime_count = 0;
   logic [NUM_W-1:0]   next_number = NUM_W'(1);
   int unsigned        limit_reg = 65536;

   sieve_result_type   pending_results[$];
   int                 mismatches = 0;
   int                 cycles = 0;
   bit                 calm = 1'b0;
   bit                 hold_request = 1'b0;

   mobius_linear_sieve dut (
      .clock(clock), .reset(reset),
      .req_tdata(req_tdata), .req_tvalid(req_tvalid), .req_tready(req_tready),
      .rsp_tdata(rsp_tdata), .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .csr_tdata(csr_tdata), .csr_tvalid(csr_tvalid), .csr_tready(csr_tready)
   );

   always #1 clock = ~clock;

   // Sieve one integer and return the result beat it should produce.
   function automatic sieve_result_type sieve_integer(logic [NUM_W-1:0] n);
      sieve_result_type r;
      int unsigned   lim;
      longint        p;
      longint        prod;
      logic [MU_W-1:0] mu_n;
      r   = '0;
      lim = (limit_reg > SIEVE_N) ? SIEVE_N : limit_reg;
      if (n != next_number || n > lim) begin
         r.total  = prime_count[TOTAL_W-1:0];
         r.status = (n != next_number) ? STATUS_ORDER : STATUS_LIMIT;
         return r;
      end
      if (n == 1) begin
         mu_store[1] = MU_ONE;
      end else if (!marks[n]) begin
         r.prime = 1'b1;
         mu_store[n] = MU_NEG;
         if (prime_count < SIEVE_PRIMES) begin
            prime_table[prime_count] = 32'(n);
            prime_count++;
         end
      end
      mu_n = mu_store[n];
      // Walk the stored primes, stopping at the first one that divides n or whose product passes the limit.
      for (int j = 0; j < prime_count; j++) begin
         p    = longint'(prime_table[j]);
         prod = p * longint'(n);
         if (prod > lim) break;
         marks[prod] = 1'b1;
         if (n % p == 0) begin
            mu_store[prod] = MU_ZERO;
            break;
         end
         mu_store[prod] = 2'b00 - mu_n;
      end
      next_number = n + 1'b1;
      r.mu     = mu_n;
      r.total  = prime_count[TOTAL_W-1:0];
      r.status = STATUS_OK;
      return r;
   endfunction

   // Send one integer; the caller stands at a falling edge and returns at one.
   task automatic send_number(input logic [NUM_W-1:0] n);
      if (!calm && $urandom_range(0, 99) < 7) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
      end
      req_tdata  <= REQ_W'(n);
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      pending_results.insert(pending_results.size(), sieve_integer(n));
      @(negedge clock);
   endtask

   // Write the limit register once every result is back.
   task automatic write_limit(input int unsigned value);
      req_tvalid <= 1'b0;
      wait (pending_results.size() == 0);
      repeat (10) @(negedge clock);
      csr_tdata  <= CSR_W'(value[NUM_W-1:0]);
      csr_tvalid <= 1'b1;
      do @(posedge clock); while (!csr_tready);
      limit_reg = 32'(value[NUM_W-1:0]);
      @(negedge clock);
      csr_tvalid <= 1'b0;
      @(negedge clock);
   endtask

   // Result checker: each beat against the oldest expectation.
   always @(posedge clock) begin
      sieve_result_type want;
      sieve_result_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[$bits(sieve_result_type)-1:0];
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result beat %h", got);
         end else begin
            want = pending_results.pop_front();
            if (got.mu !== want.mu || got.prime !== want.prime ||
                got.total !== want.total || got.status !== want.status) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected mu %b prime %b total %0d status %0d, ",
                           want.mu, want.prime, want.total, want.status,
                           "got mu %b prime %b total %0d status %0d",
                           got.mu, got.prime, got.total, got.status);
            end
         end
      end
   end

   // Receiver: random stalls, a quiet mode, and a long hold on request.
   initial begin
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_tready <= 1'b0;
            repeat (400) @(negedge clock);
         end
         rsp_tready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 7);
      end
   end

   // Cycle limit.
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAIL mobius_linear_sieve");
         $finish;
      end
   end

   // A zero limit rejects everything; wrong order wins over the limit.
   task automatic test_rejects();
      write_limit(0);
      send_number(17'd1);
      send_number(17'd5);
      send_number(17'd0);
      send_number(17'h1FFFF);
   endtask

   // Small limit: the first integers, then one past the limit.
   task automatic test_small_limit();
      write_limit(10);
      for (int i = 1; i <= 10; i++) send_number(NUM_W'(i));
      send_number(17'd11);
      send_number(17'h10000);
      send_number(17'd10);
   endtask

   // Raise the limit mid-run so unsieved integers count as unmarked.
   task automatic test_limit_raise();
      write_limit(40);
      while (next_number <= 40) send_number(next_number);
      write_limit(17'h1FFFF);
      repeat (8) send_number(next_number);
   endtask

   // Mostly in-order integers with out-of-order noise, under a random limit.
   task automatic test_random_run(input int count, input bit quiet);
      logic [NUM_W-1:0] n;
      if ($urandom_range(0, 2) == 0) write_limit(65536);
      else write_limit(next_number + $urandom_range(30, 350));
      calm = quiet;
      repeat (count) begin
         n = next_number;
         if ($urandom_range(0, 99) < 10) n = NUM_W'($urandom_range(0, 17'h1FFFF));
         send_number(n);
      end
      calm = 1'b0;
   endtask

   // Long receiver hold while integers keep coming, so the input stalls.
   task automatic test_backpressure();
      hold_request = 1'b1;
      repeat (150) send_number(next_number);
   endtask

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_rejects();
      test_small_limit();
      test_limit_raise();
      test_random_run(300, 1'b0);
      test_random_run(300, 1'b1);
      test_backpressure();
      test_random_run(300, 1'b0);
      test_random_run(300, 1'b0);
      test_random_run(300, 1'b0);
      req_tvalid <= 1'b0;
      wait (pending_results.size() == 0);
      repeat (50) @(posedge clock);
      if (mismatches == 0) begin
         $display("PASS mobius_linear_sieve");
      end else begin
         $display("FAIL mobius_linear_sieve");
      end
      $finish;
   end

endmodule
